// File: hdl/trkang_pkg.sv
// ----------------------------------------------------------------------------
// trkang_pkg
// Shared constants, types and tables for the track opening angle unit.
// ----------------------------------------------------------------------------
package trkang_pkg;

	// Angle scale and CORDIC depth
	localparam int ANGLE_BITS    = 16;
	localparam int CORDIC_STAGES = 16;

	// Port widths
	localparam int IN_W  = 16;
	localparam int OUT_W = 16;

	// Datapath widths
	localparam int CW       = 34;  // CORDIC x/y/z, Q2.30 values and turn angles
	localparam int PROD_W   = 2 * CW;
	localparam int SQ_W     = 62;  // radicand and root in the square root pipe
	localparam int SQ_STEPS = 31;  // one result bit per step, radicand < 2^61
	localparam int DEG_W    = 50;

	localparam int LATENCY = 2 * CORDIC_STAGES + 41;

	localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [CW-1:0] Q_ONE       = 34'sd1073741824;
	localparam logic signed [CW-1:0] QUARTER     = 34'sd1073741824;
	localparam logic [16:0]          DEG_PER_TURN  = 17'd92160;
	localparam logic [OUT_W-1:0]     DEG_HALF_TURN = 16'd46080;

	typedef logic [31:0]          turn_t;
	typedef logic signed [CW-1:0] cval_t;

	// atan(2^-i) in 32-bit turn units
	function automatic cval_t atan_turn(input logic [4:0] idx);
		cval_t r;
		unique case (idx)
			5'd0:  r = 34'sd536870912;
			5'd1:  r = 34'sd316933406;
			5'd2:  r = 34'sd167458907;
			5'd3:  r = 34'sd85004756;
			5'd4:  r = 34'sd42667331;
			5'd5:  r = 34'sd21354465;
			5'd6:  r = 34'sd10679838;
			5'd7:  r = 34'sd5340245;
			5'd8:  r = 34'sd2670163;
			5'd9:  r = 34'sd1335087;
			5'd10: r = 34'sd667544;
			5'd11: r = 34'sd333772;
			5'd12: r = 34'sd166886;
			5'd13: r = 34'sd83443;
			5'd14: r = 34'sd41722;
			5'd15: r = 34'sd20861;
			5'd16: r = 34'sd10430;
			5'd17: r = 34'sd5215;
			5'd18: r = 34'sd2608;
			5'd19: r = 34'sd1304;
			5'd20: r = 34'sd652;
			5'd21: r = 34'sd326;
			5'd22: r = 34'sd163;
			5'd23: r = 34'sd81;
			default: r = '0;
		endcase
		return r;
	endfunction

	// Binary angle to a 32-bit turn
	function automatic turn_t to_turn(input logic [IN_W-1:0] v);
		logic [31:0] m;
		m = 32'(v) & 32'((64'd1 << ANGLE_BITS) - 64'd1);
		return m << (32 - ANGLE_BITS);
	endfunction

endpackage

// File: hdl/trkang_sincos.sv
// ----------------------------------------------------------------------------
// trkang_sincos
// Pipelined rotation CORDIC: sine and cosine of a 32-bit turn, Q2.30.
// ----------------------------------------------------------------------------
module trkang_sincos (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  trkang_pkg::turn_t    angle,
	output logic                 out_valid,
	output trkang_pkg::cval_t    cos_val,
	output trkang_pkg::cval_t    sin_val
);
	import trkang_pkg::*;

	turn_t a_rot;
	logic  fold;
	turn_t a_sum;

	cval_t x_s [0:CORDIC_STAGES];
	cval_t y_s [0:CORDIC_STAGES];
	cval_t z_s [0:CORDIC_STAGES];
	logic  neg_s [0:CORDIC_STAGES];
	logic  vld_s [0:CORDIC_STAGES];

	// fold into [-pi/2, pi/2)
	always_comb begin
		a_sum = angle + 32'h4000_0000;
		fold  = a_sum[31];
		a_rot = fold ? angle + 32'h8000_0000 : angle;
	end

	always_ff @(posedge clk) begin
		x_s[0]   <= CORDIC_GAIN;
		y_s[0]   <= '0;
		z_s[0]   <= {{(CW-32){a_rot[31]}}, a_rot};
		neg_s[0] <= fold;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
		end
	end

	// rotation stages
	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
		always_ff @(posedge clk) begin
			if (!z_s[i][CW-1]) begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - atan_turn(5'(i));
			end else begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + atan_turn(5'(i));
			end
			neg_s[i+1] <= neg_s[i];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end
	end

	// undo the fold
	always_ff @(posedge clk) begin
		cos_val <= neg_s[CORDIC_STAGES] ? -x_s[CORDIC_STAGES] : x_s[CORDIC_STAGES];
		sin_val <= neg_s[CORDIC_STAGES] ? -y_s[CORDIC_STAGES] : y_s[CORDIC_STAGES];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= vld_s[CORDIC_STAGES];
		end
	end

endmodule

// File: hdl/trkang_cosmix.sv
// ----------------------------------------------------------------------------
// trkang_cosmix
// Cosine of the opening angle: sA*sB*cos(dAz) + cA*cB, clamped to [-1, 1].
// ----------------------------------------------------------------------------
module trkang_cosmix (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  trkang_pkg::cval_t    sin_a,
	input  trkang_pkg::cval_t    cos_a,
	input  trkang_pkg::cval_t    sin_b,
	input  trkang_pkg::cval_t    cos_b,
	input  trkang_pkg::cval_t    cos_d,
	output logic                 out_valid,
	output trkang_pkg::cval_t    cos_open
);
	import trkang_pkg::*;

	logic signed [PROD_W-1:0] ss_s1, cc_s1;
	cval_t                    cd_s1;
	logic signed [PROD_W-1:0] m_s2;
	logic signed [PROD_W-1:0] cc_s2;
	logic                     vld_s1, vld_s2;

	logic signed [PROD_W-1:0] ss_sh, m_sh, sum;

	// stage 1: the two polar products
	always_ff @(posedge clk) begin
		ss_s1 <= PROD_W'(sin_a) * PROD_W'(sin_b);
		cc_s1 <= PROD_W'(cos_a) * PROD_W'(cos_b);
		cd_s1 <= cos_d;
	end

	// stage 2: times the azimuth cosine
	always_comb begin
		ss_sh = ss_s1 >>> 30;
		m_sh  = m_s2 >>> 30;
		sum   = m_sh + cc_s2;
	end

	always_ff @(posedge clk) begin
		m_s2  <= PROD_W'($signed(ss_sh[CW-1:0])) * PROD_W'(cd_s1);
		cc_s2 <= cc_s1 >>> 30;
	end

	// stage 3: sum and clamp
	always_ff @(posedge clk) begin
		if (sum > PROD_W'(Q_ONE)) begin
			cos_open <= Q_ONE;
		end else if (sum < -PROD_W'(Q_ONE)) begin
			cos_open <= -Q_ONE;
		end else begin
			cos_open <= sum[CW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			vld_s1    <= in_valid;
			vld_s2    <= vld_s1;
			out_valid <= vld_s2;
		end
	end

endmodule

// File: hdl/trkang_sqrt.sv
// ----------------------------------------------------------------------------
// trkang_sqrt
// Pipelined integer square root of 2^60 - c*c, one result bit per stage.
// ----------------------------------------------------------------------------
module trkang_sqrt (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  trkang_pkg::cval_t    cos_in,
	output logic                 out_valid,
	output trkang_pkg::cval_t    cos_out,
	output trkang_pkg::cval_t    sin_out
);
	import trkang_pkg::*;

	logic signed [PROD_W-1:0] sq_s1;
	cval_t                    c_s1;
	logic                     vld_s1;

	logic [SQ_W-1:0] rem_s  [0:SQ_STEPS];
	logic [SQ_W-1:0] root_s [0:SQ_STEPS];
	cval_t           c_s    [0:SQ_STEPS];
	logic            vld_s  [0:SQ_STEPS];

	// square
	always_ff @(posedge clk) begin
		sq_s1 <= PROD_W'(cos_in) * PROD_W'(cos_in);
		c_s1  <= cos_in;
	end

	// radicand
	always_ff @(posedge clk) begin
		rem_s[0]  <= (SQ_W'(1) << 60) - sq_s1[SQ_W-1:0];
		root_s[0] <= '0;
		c_s[0]    <= c_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			vld_s[0] <= 1'b0;
		end else begin
			vld_s1   <= in_valid;
			vld_s[0] <= vld_s1;
		end
	end

	// digit steps
	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
		localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (60 - 2 * k);
		logic [SQ_W-1:0] trial;

		assign trial = root_s[k] + BIT;

		always_ff @(posedge clk) begin
			if (rem_s[k] >= trial) begin
				rem_s[k+1]  <= rem_s[k] - trial;
				root_s[k+1] <= (root_s[k] >> 1) + BIT;
			end else begin
				rem_s[k+1]  <= rem_s[k];
				root_s[k+1] <= root_s[k] >> 1;
			end
			c_s[k+1] <= c_s[k];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end
	end

	assign out_valid = vld_s[SQ_STEPS];
	assign cos_out   = c_s[SQ_STEPS];
	assign sin_out   = $signed(root_s[SQ_STEPS][CW-1:0]);

endmodule

// File: hdl/trkang_acos.sv
// ----------------------------------------------------------------------------
// trkang_acos
// Vectoring CORDIC atan2(s, c) and conversion to degrees, 8 fraction bits.
// ----------------------------------------------------------------------------
module trkang_acos (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  trkang_pkg::cval_t         cos_in,
	input  trkang_pkg::cval_t         sin_in,
	output logic                      out_valid,
	output logic [trkang_pkg::OUT_W-1:0] degrees
);
	import trkang_pkg::*;

	cval_t x_s [0:CORDIC_STAGES];
	cval_t y_s [0:CORDIC_STAGES];
	cval_t z_s [0:CORDIC_STAGES];
	logic  vld_s [0:CORDIC_STAGES];

	logic [DEG_W-1:0] prod_s1;
	logic             vld_p;
	logic [DEG_W-1:0] rounded;
	logic [DEG_W-33:0] deg_raw;
	logic [CW-2:0]    z_pos;

	// start vector, quarter turn ahead for negative cosine
	always_ff @(posedge clk) begin
		if (cos_in[CW-1]) begin
			x_s[0] <= sin_in;
			y_s[0] <= -cos_in;
			z_s[0] <= QUARTER;
		end else begin
			x_s[0] <= cos_in;
			y_s[0] <= sin_in;
			z_s[0] <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
		end
	end

	// vectoring stages
	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_vec
		logic y_pos;
		assign y_pos = !y_s[i][CW-1] && (y_s[i] != '0);

		always_ff @(posedge clk) begin
			if (y_pos) begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + atan_turn(5'(i));
			end else begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - atan_turn(5'(i));
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end
	end

	// turns to degrees: clamp at zero, scale
	assign z_pos = z_s[CORDIC_STAGES][CW-1] ? '0 : z_s[CORDIC_STAGES][CW-2:0];

	always_ff @(posedge clk) begin
		prod_s1 <= DEG_W'(z_pos) * DEG_W'(DEG_PER_TURN);
	end

	// round half up, clamp at half a turn
	always_comb begin
		rounded = prod_s1 + (DEG_W'(1) << 31);
		deg_raw = rounded[DEG_W-1:32];
	end

	always_ff @(posedge clk) begin
		if (deg_raw > (DEG_W-32)'(DEG_HALF_TURN)) begin
			degrees <= DEG_HALF_TURN;
		end else begin
			degrees <= deg_raw[OUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_p     <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			vld_p     <= vld_s[CORDIC_STAGES];
			out_valid <= vld_p;
		end
	end

endmodule

// File: hdl/track_kink_angle_3d_unit.sv
// ----------------------------------------------------------------------------
// track_kink_angle_3d_unit
// Opening angle between two track directions given as polar/azimuth angles.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle; busy is held low, start may be high every cycle.
// The depth is set by the two CORDIC pipes and the 31-step square root pipe.
// Reset clears only the valid bits; no word is in flight after reset.
// The receiver cannot stall: done marks opening_degrees for one cycle.
module track_kink_angle_3d_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [trkang_pkg::IN_W-1:0]   polar_first,
	input  logic [trkang_pkg::IN_W-1:0]   polar_second,
	input  logic signed [trkang_pkg::IN_W-1:0] azimuth_first,
	input  logic signed [trkang_pkg::IN_W-1:0] azimuth_second,
	output logic                          done,
	output logic [trkang_pkg::OUT_W-1:0]  opening_degrees
);
	import trkang_pkg::*;

	turn_t pa, pb, da;
	logic  go;

	logic  sc_vld_a, sc_vld_b, sc_vld_d;
	cval_t cos_a, sin_a, cos_b, sin_b, cos_d, sin_d;

	logic  cm_vld;
	cval_t cos_open;

	logic  sq_vld;
	cval_t sq_cos, sq_sin;

	assign busy = 1'b0;
	assign go   = start && !busy;

	// angles to turns
	assign pa = to_turn(polar_first);
	assign pb = to_turn(polar_second);
	assign da = to_turn(azimuth_first) - to_turn(azimuth_second);

	trkang_sincos u_sc_a (
		.clk(clk), .arst_n(arst_n), .in_valid(go), .angle(pa),
		.out_valid(sc_vld_a), .cos_val(cos_a), .sin_val(sin_a)
	);

	trkang_sincos u_sc_b (
		.clk(clk), .arst_n(arst_n), .in_valid(go), .angle(pb),
		.out_valid(sc_vld_b), .cos_val(cos_b), .sin_val(sin_b)
	);

	trkang_sincos u_sc_d (
		.clk(clk), .arst_n(arst_n), .in_valid(go), .angle(da),
		.out_valid(sc_vld_d), .cos_val(cos_d), .sin_val(sin_d)
	);

	trkang_cosmix u_mix (
		.clk(clk), .arst_n(arst_n), .in_valid(sc_vld_a),
		.sin_a(sin_a), .cos_a(cos_a), .sin_b(sin_b), .cos_b(cos_b), .cos_d(cos_d),
		.out_valid(cm_vld), .cos_open(cos_open)
	);

	trkang_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .in_valid(cm_vld), .cos_in(cos_open),
		.out_valid(sq_vld), .cos_out(sq_cos), .sin_out(sq_sin)
	);

	trkang_acos u_acos (
		.clk(clk), .arst_n(arst_n), .in_valid(sq_vld),
		.cos_in(sq_cos), .sin_in(sq_sin),
		.out_valid(done), .degrees(opening_degrees)
	);

	// the three sine/cosine pipes stay aligned
	a_sc_align: assert property (@(posedge clk) disable iff (!arst_n)
		(sc_vld_a == sc_vld_b) && (sc_vld_a == sc_vld_d) &&
		((sin_d == sin_d) || !sc_vld_d))
		else $error("sine/cosine pipes out of step");

	// every accepted word comes out after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		go |-> ##LATENCY done)
		else $error("result missing after latency");

	// no result without a word taken earlier
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(go, LATENCY))
		else $error("result without a word");

	// clamped cosine stays within one
	a_cos_range: assert property (@(posedge clk) disable iff (!arst_n)
		cm_vld |-> (cos_open <= Q_ONE) && (cos_open >= -Q_ONE))
		else $error("cosine out of range");

	// angle never beyond half a turn
	a_deg_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (opening_degrees <= DEG_HALF_TURN))
		else $error("angle beyond 180 degrees");

endmodule

// File: dv/track_angle_checker.sv
// ----------------------------------------------------------------------------
// track_angle_checker
// Watches the start/busy input channel and the done strobe of the opening
// angle unit, predicts every opening angle and compares it with the result.
// ----------------------------------------------------------------------------
module track_angle_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [15:0] polar_first,
	input  logic [15:0] polar_second,
	input  logic [15:0] azimuth_first,
	input  logic [15:0] azimuth_second,
	input  logic        done,
	input  logic [15:0] opening_degrees,
	output int          fail_count,
	output int          pending
);
	import trkang_pkg::*;

	localparam longint GAIN_Q30 = 652032874;
	localparam longint ONE_Q30  = 1073741824;

	logic [15:0] angle_queue[$];
	int          mismatches;

	// arctangent of 2^-i in 32-bit turn units
	function automatic longint atan_step(input int i);
		longint tbl[24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
			21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772,
			166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326,
			163, 81};
		return tbl[i];
	endfunction

	// arithmetic shift right, rounds toward minus infinity
	function automatic longint shr(input longint v, input int s);
		return v >>> s;
	endfunction

	function automatic logic [31:0] turn_of(input logic [15:0] v);
		logic [31:0] m;
		m = {16'd0, v} & ((32'd1 << ANGLE_BITS) - 32'd1);
		return m << (32 - ANGLE_BITS);
	endfunction

	// rotation CORDIC: cosine and sine of a turn angle, Q30
	function automatic void rotate(input logic [31:0] a, output longint c,
			output longint s);
		logic   neg;
		longint x, y, z, dx, dy;
		neg = a[31] ^ a[30];
		x = GAIN_Q30;
		y = 0;
		if (neg)
			a = a + 32'h8000_0000;
		z = longint'(signed'(a));
		for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
			dx = shr(y, i);
			dy = shr(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= atan_step(i);
			end else begin
				x += dx; y -= dy; z += atan_step(i);
			end
		end
		c = neg ? -x : x;
		s = neg ? -y : y;
	endfunction

	function automatic longint int_sqrt(input logic [63:0] v);
		logic [63:0] res, bt;
		res = 0;
		bt = 64'd1 << 62;
		while (bt > v)
			bt >>= 2;
		while (bt != 0) begin
			if (v >= res + bt) begin
				v -= res + bt;
				res = (res >> 1) + bt;
			end else begin
				res >>= 1;
			end
			bt >>= 2;
		end
		return longint'(res);
	endfunction

	function automatic logic [15:0] opening_angle(input logic [15:0] pa_in,
			input logic [15:0] pb_in, input logic [15:0] aa_in, input logic [15:0] ab_in);
		longint ca, sa, cb, sb, cd, sd, c, s, x, y, z, dx, dy, deg;
		rotate(turn_of(pa_in), ca, sa);
		rotate(turn_of(pb_in), cb, sb);
		rotate(turn_of(aa_in) - turn_of(ab_in), cd, sd);
		c = shr(shr(sa * sb, 30) * cd, 30) + shr(ca * cb, 30);
		if (c > ONE_Q30) c = ONE_Q30;
		if (c < -ONE_Q30) c = -ONE_Q30;
		s = int_sqrt((64'd1 << 60) - 64'(c * c));
		// vectoring CORDIC; negative cosine starts a quarter turn on
		if (c < 0) begin
			x = s; y = -c; z = 64'h4000_0000;
		end else begin
			x = c; y = s; z = 0;
		end
		for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
			dx = shr(y, i);
			dy = shr(x, i);
			if (y > 0) begin
				x += dx; y -= dy; z += atan_step(i);
			end else begin
				x -= dx; y += dy; z -= atan_step(i);
			end
		end
		if (z < 0) z = 0;
		deg = (z * 92160 + (64'sd1 << 31)) >>> 32;
		if (deg > 46080) deg = 46080;
		return deg[15:0];
	endfunction

	assign fail_count = mismatches;
	assign pending    = angle_queue.size();

	// predict on every accepted word, compare on every done strobe
	always @(posedge clk or negedge arst_n) begin
		logic [15:0] want;
		if (!arst_n) begin
			angle_queue.delete();
			mismatches = 0;
		end else begin
			if (done) begin
				if (angle_queue.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result %0d", opening_degrees);
				end else begin
					want = angle_queue.pop_front();
					if (want !== opening_degrees) begin
						mismatches++;
						if (mismatches <= 10)
							$display("opening_degrees: expected %0d got %0d",
								want, opening_degrees);
					end
				end
			end
			if (start && !busy)
				angle_queue.push_back(opening_angle(polar_first, polar_second,
					azimuth_first, azimuth_second));
		end
	end
endmodule

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random track pairs into the opening angle unit with
// random gaps; the checker predicts and compares each result.
// ----------------------------------------------------------------------------
module testbench;
	import trkang_pkg::*;

	localparam int LIMIT = 400000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        start = 0;
	logic        busy;
	logic [15:0] polar_first = 0, polar_second = 0;
	logic [15:0] azimuth_first = 0, azimuth_second = 0;
	logic        done;
	logic [15:0] opening_degrees;
	int          fail_count, pending;
	int          cycles = 0;

	always #10 clk = ~clk;

	track_kink_angle_3d_unit dut (
		.clk, .arst_n, .start, .busy, .polar_first, .polar_second,
		.azimuth_first, .azimuth_second, .done, .opening_degrees
	);

	track_angle_checker chk (
		.clk, .arst_n, .start, .busy, .polar_first, .polar_second,
		.azimuth_first, .azimuth_second, .done, .opening_degrees,
		.fail_count, .pending
	);

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 80);
	endfunction

	// present one word, hold start until accepted, then maybe idle
	task automatic send_word(input logic [15:0] pa, input logic [15:0] pb,
			input logic [15:0] aa, input logic [15:0] ab);
		int g;
		start <= 1;
		polar_first <= pa;
		polar_second <= pb;
		azimuth_first <= aa;
		azimuth_second <= ab;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		g = gap_len();
		if (g > 0) begin
			start <= 0;
			repeat (g) @(posedge clk);
		end
	endtask

	function automatic logic [15:0] rnd_polar();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 16'($urandom);
		if (r == 1) return $urandom_range(0, 1) ? 16'd0 : 16'd32768;
		return 16'($urandom_range(0, 32768));
	endfunction

	initial begin
		logic [15:0] edges[6] = '{16'd0, 16'd32768, 16'd16384, 16'hFFFF, 16'h7FFF, 16'h8001};
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// extremes, on-axis tracks, opposite and equal directions
		for (int i = 0; i < 6; i++)
			send_word(edges[i], edges[(i + 1) % 6], edges[(i + 2) % 6], edges[(i + 4) % 6]);
		send_word(16'd0, 16'd0, 16'h8000, 16'h7FFF);
		send_word(16'd0, 16'd32768, 16'd0, 16'd0);
		send_word(16'd0, 16'd12345, 16'h1234, 16'hC000);
		send_word(16'd20000, 16'd32768, 16'h8000, 16'h0000);
		send_word(16'd16384, 16'd16384, 16'h0000, 16'h8000);
		send_word(16'd16384, 16'd16384, 16'h4000, 16'h4000);
		send_word(16'd10000, 16'd10000, 16'h7FFF, 16'h8000);
		send_word(16'd40000, 16'd3000, 16'hFFFF, 16'h0001);
		send_word(16'd1, 16'd1, 16'd1, 16'd0);
		for (int n = 0; n < 1050; n++)
			send_word(rnd_polar(), rnd_polar(), 16'($urandom), 16'($urandom));
		start <= 0;
		while (pending != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (fail_count == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end
endmodule

// File: filelist.f
hdl/trkang_pkg.sv
hdl/trkang_sincos.sv
hdl/trkang_cosmix.sv
hdl/trkang_sqrt.sv
hdl/trkang_acos.sv
hdl/track_kink_angle_3d_unit.sv
dv/track_angle_checker.sv
dv/testbench.sv
